// File: rtl/core/htbd_pkg.sv
// shared types and constants for the huffman tree bit decoder
`default_nettype none

package htbd_pkg;

  localparam int MaxNodes    = 1024;
  localparam int NodeAw      = $clog2(MaxNodes);
  localparam int MaxCodeBits = 32;
  localparam int ValueBits   = 16;
  localparam int LimitW      = 11;
  localparam int LenW        = 6;
  localparam int CountW      = 12;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_DECODE = 2'd2,
    KIND_CURSOR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NEED_MORE = 2'd1,
    STAT_SYMBOL    = 2'd2,
    STAT_ERROR     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CH_UNUSED  = 2'd0,
    CH_POINTER = 2'd1,
    CH_LEAF    = 2'd2
  } child_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_DEC
  } state_e;

  // one child: leaf value or pointer index in the low bits
  typedef struct packed {
    child_e                 kind;
    logic [ValueBits-1:0]   data;
  } child_t;

  typedef struct packed {
    child_t one;
    child_t zero;
  } node_t;

  localparam int NodeW = $bits(node_t);

  typedef struct packed {
    kind_e                  kind;
    logic [MaxCodeBits-1:0] code_word;
    logic [LenW-1:0]        code_length;
    logic [ValueBits-1:0]   symbol_value;
    logic                   data_bit;
  } item_t;

  typedef struct packed {
    status_e                status;
    logic [ValueBits-1:0]   decoded_value;
    logic                   bit_used;
    logic [CountW-1:0]      code_count;
    logic [LenW-1:0]        longest_code;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/huffman_tree_bit_decoder.sv
// top level of the bit-serial huffman tree decoder with codebook build
//
// channel   direction  handshake                 payload
// command   in         start / busy              item_i   (item_t)
// result    out        result_valid_o strobe     result_o (result_t)
// config    in         cfg_we_i, no wait         cfg_wdata_i (node_limit)
//
// a beat is taken at a rising edge with start high and busy low
// clear, cursor reset, null code add, rejected adds, null decode and decode from an
// unclaimed cursor: answered without leaving idle, busy stays low
// decode one bit from a claimed cursor: one registered node ram read, then the child is checked
// add of length L: one node read-modify-write per code bit,
// fewer when the node limit stops the walk
// the result strobe is high for one cycle, the cycle after the last work cycle;
// the receiver cannot stall, so a new beat may be taken while it is shown
// reset clears all control state; node ram contents stay undefined, each node is
// zeroed when claimed, so no unwritten entry is ever used
`default_nettype none

module huffman_tree_bit_decoder import htbd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output      logic              busy,
  input  wire item_t             item_i,
  output      logic              result_valid_o,
  output      result_t           result_o,
  input  wire logic              cfg_we_i,
  input  wire logic [LimitW-1:0] cfg_wdata_i
);

  // control and codebook state
  state_e                 state_q, state_d;
  logic [NodeAw-1:0]      cur_q, cur_d;
  logic [MaxCodeBits-1:0] code_q, code_d;
  logic [LenW-1:0]        rem_q, rem_d;
  logic [ValueBits-1:0]   sym_q, sym_d;
  logic                   bit_q, bit_d;
  logic [LimitW-1:0]      next_free_q, next_free_d;
  logic [NodeAw-1:0]      cursor_q, cursor_d;
  logic [CountW-1:0]      leaf_count_q, leaf_count_d;
  logic [LenW-1:0]        max_len_q, max_len_d;
  logic                   null_present_q, null_present_d;
  logic [ValueBits-1:0]   null_symbol_q, null_symbol_d;
  logic [LimitW-1:0]      node_limit_q;
  result_t                res_q, res_d;
  logic                   res_valid_q, res_valid_d;

  // node ram port signals
  logic              ram_we, ram_re;
  logic [NodeAw-1:0] ram_waddr, ram_raddr;
  node_t             ram_wdata, ram_rdata;
  logic [NodeW-1:0]  ram_rdata_raw;

  logic [LimitW-1:0] limit_eff;
  logic              accept;

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign ram_rdata = node_t'(ram_rdata_raw);

  // out of range limit acts as the full store
  assign limit_eff = (node_limit_q == '0 || node_limit_q > LimitW'(MaxNodes)) ?
                     LimitW'(MaxNodes) : node_limit_q;

  htbd_ram #(
    .Width (NodeW),
    .Depth (MaxNodes)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  always_comb begin
    logic              done;
    status_e           st;
    logic [ValueBits-1:0] dval;
    logic              used;
    logic              claim;
    node_t             node;
    node_t             new_node;
    child_t            old_ch;
    child_t            new_ch;
    child_t            dec_ch;
    logic [LimitW-1:0] nf;
    logic              side;
    logic              wr;

    state_d        = state_q;
    cur_d          = cur_q;
    code_d         = code_q;
    rem_d          = rem_q;
    sym_d          = sym_q;
    bit_d          = bit_q;
    next_free_d    = next_free_q;
    cursor_d       = cursor_q;
    leaf_count_d   = leaf_count_q;
    max_len_d      = max_len_q;
    null_present_d = null_present_q;
    null_symbol_d  = null_symbol_q;

    ram_re    = 1'b0;
    ram_raddr = cursor_q;
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = ram_rdata;

    done = 1'b0;
    st   = STAT_OK;
    dval = '0;
    used = 1'b0;

    claim    = ({1'b0, cur_q} >= next_free_q);
    node     = claim ? node_t'('0) : ram_rdata;
    nf       = claim ? ({1'b0, cur_q} + LimitW'(1)) : next_free_q;
    side     = code_q[MaxCodeBits-1];
    old_ch   = side ? node.one : node.zero;
    new_ch   = old_ch;
    new_node = node;
    wr       = 1'b0;
    dec_ch   = bit_q ? ram_rdata.one : ram_rdata.zero;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (item_i.kind)
            KIND_CLEAR: begin
              next_free_d    = '0;
              leaf_count_d   = '0;
              max_len_d      = '0;
              null_present_d = 1'b0;
              null_symbol_d  = '0;
              cursor_d       = '0;
              done           = 1'b1;
            end
            KIND_ADD: begin
              if (item_i.code_length > LenW'(MaxCodeBits)) begin
                done = 1'b1;
                st   = STAT_ERROR;
              end else if (item_i.code_length == '0) begin
                null_symbol_d  = item_i.symbol_value;
                null_present_d = 1'b1;
                done           = 1'b1;
              end else begin
                null_present_d = 1'b0;
                if (item_i.code_length > max_len_q) begin
                  max_len_d = item_i.code_length;
                end
                // left align the code so the walk takes the top bit
                code_d    = item_i.code_word << (LenW'(MaxCodeBits) - item_i.code_length);
                rem_d     = item_i.code_length;
                sym_d     = item_i.symbol_value;
                cur_d     = '0;
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_d   = ST_ADD;
              end
            end
            KIND_DECODE: begin
              if (null_present_q) begin
                done     = 1'b1;
                st       = STAT_SYMBOL;
                dval     = null_symbol_q;
                cursor_d = '0;
              end else if ({1'b0, cursor_q} >= next_free_q) begin
                done     = 1'b1;
                st       = STAT_ERROR;
                used     = 1'b1;
                cursor_d = '0;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = cursor_q;
                bit_d     = item_i.data_bit;
                state_d   = ST_DEC;
              end
            end
            KIND_CURSOR: begin
              cursor_d = '0;
              done     = 1'b1;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      ST_DEC: begin
        done    = 1'b1;
        used    = 1'b1;
        state_d = ST_IDLE;
        case (dec_ch.kind)
          CH_LEAF: begin
            st       = STAT_SYMBOL;
            dval     = dec_ch.data;
            cursor_d = '0;
          end
          CH_POINTER: begin
            st       = STAT_NEED_MORE;
            cursor_d = dec_ch.data[NodeAw-1:0];
          end
          default: begin
            st       = STAT_ERROR;
            cursor_d = '0;
          end
        endcase
      end

      ST_ADD: begin
        // a claimed node is written back cleared even if the add fails here
        wr          = claim;
        next_free_d = nf;
        if (rem_q == LenW'(1)) begin
          new_ch.kind = CH_LEAF;
          new_ch.data = sym_q;
          if (old_ch.kind != CH_LEAF) begin
            leaf_count_d = leaf_count_q + CountW'(1);
          end
          wr      = 1'b1;
          done    = 1'b1;
          state_d = ST_IDLE;
        end else if (old_ch.kind == CH_POINTER) begin
          cur_d     = old_ch.data[NodeAw-1:0];
          ram_re    = 1'b1;
          ram_raddr = old_ch.data[NodeAw-1:0];
          code_d    = code_q << 1;
          rem_d     = rem_q - LenW'(1);
        end else if (nf >= limit_eff) begin
          done    = 1'b1;
          st      = STAT_ERROR;
          state_d = ST_IDLE;
        end else begin
          if (old_ch.kind == CH_LEAF && leaf_count_q != '0) begin
            leaf_count_d = leaf_count_q - CountW'(1);
          end
          new_ch.kind = CH_POINTER;
          new_ch.data = ValueBits'(nf);
          wr          = 1'b1;
          cur_d       = nf[NodeAw-1:0];
          ram_re      = 1'b1;
          ram_raddr   = nf[NodeAw-1:0];
          code_d      = code_q << 1;
          rem_d       = rem_q - LenW'(1);
        end
        if (side) begin
          new_node.one = new_ch;
        end else begin
          new_node.zero = new_ch;
        end
        ram_we    = wr;
        ram_waddr = cur_q;
        ram_wdata = new_node;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // result beat carries the counters as they stand after the item
    res_valid_d = done;
    res_d       = res_q;
    if (done) begin
      res_d.status        = st;
      res_d.decoded_value = dval;
      res_d.bit_used      = used;
      res_d.code_count    = leaf_count_d;
      res_d.longest_code  = max_len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      next_free_q    <= '0;
      cursor_q       <= '0;
      leaf_count_q   <= '0;
      max_len_q      <= '0;
      null_present_q <= 1'b0;
      null_symbol_q  <= '0;
      node_limit_q   <= LimitW'(MaxNodes);
      res_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      next_free_q    <= next_free_d;
      cursor_q       <= cursor_d;
      leaf_count_q   <= leaf_count_d;
      max_len_q      <= max_len_d;
      null_present_q <= null_present_d;
      null_symbol_q  <= null_symbol_d;
      res_valid_q    <= res_valid_d;
      if (cfg_we_i) begin
        node_limit_q <= cfg_wdata_i;
      end
    end
  end

  // walk registers and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    code_q <= code_d;
    rem_q  <= rem_d;
    sym_q  <= sym_d;
    bit_q  <= bit_d;
    res_q  <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // a result beat always closes an accept cycle or a work cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(start && !busy) || $past(busy)))
    else $error("result strobe without a finished item");

  // the cursor only ever points at a claimed node, or at the root
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cursor_q == '0) || ({1'b0, cursor_q} < next_free_q))
    else $error("cursor beyond claimed nodes");

  // claimed nodes never exceed the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= LimitW'(MaxNodes))
    else $error("node allocation past store depth");

  // every leaf lives in a claimed node, two children each
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    leaf_count_q <= {next_free_q, 1'b0})
    else $error("leaf count exceeds claimed children");

endmodule

`default_nettype wire

// File: rtl/core/htbd_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module htbd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
